// File: design/lduv_pkg.sv
// Shared types and constants for the LDAP URL validator.
// Has no dependencies. The parser, the result buffer and the top level use it.
`default_nettype none

package lduv_pkg;

    localparam int LEN_W   = 11;
    localparam int PARTS   = 5;
    localparam logic [LEN_W-1:0] LEN_SAT = 11'd2047;

    // Positions in present_mask and in the part length array.
    localparam int PART_HOST   = 0;
    localparam int PART_PORT   = 1;
    localparam int PART_BASEDN = 2;
    localparam int PART_ATTR   = 3;
    localparam int PART_DEEP   = 4;

    localparam logic [3:0] PREFIX_NONE   = 4'd0;
    localparam logic [3:0] PREFIX_PLAIN  = 4'd7;
    localparam logic [3:0] PREFIX_SECURE = 4'd8;

    localparam logic [7:0] CH_SLASH    = 8'h2F;
    localparam logic [7:0] CH_QUESTION = 8'h3F;
    localparam logic [7:0] CH_COLON    = 8'h3A;
    localparam logic [7:0] CH_DASH     = 8'h2D;
    localparam logic [7:0] CH_DOT      = 8'h2E;
    localparam logic [7:0] CH_UNDER    = 8'h5F;

    typedef struct packed {
        logic [7:0] url_byte;
        logic       last;
        logic       end_only;
    } in_t;

    typedef struct packed {
        logic             url_valid;
        logic [3:0]       prefix_len;
        logic [PARTS-1:0] present_mask;
        logic [LEN_W-1:0] host_len;
        logic [LEN_W-1:0] port_len;
        logic [LEN_W-1:0] basedn_len;
        logic [LEN_W-1:0] attribute_len;
        logic [LEN_W-1:0] deep_len;
        logic             overflow;
    } out_t;

    // Bytes of "ldap://" and "ldaps://" by position.
    function automatic logic [7:0] scheme_plain(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h64;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h3A;
            3'd5:    ch = 8'h2F;
            3'd6:    ch = 8'h2F;
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] scheme_secure(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = 8'h6C;
            3'd1:    ch = 8'h64;
            3'd2:    ch = 8'h61;
            3'd3:    ch = 8'h70;
            3'd4:    ch = 8'h73;
            3'd5:    ch = 8'h3A;
            3'd6:    ch = 8'h2F;
            default: ch = 8'h2F;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: design/ldap_url_validator.sv
// Top level of the LDAP URL validator: parser plus buffered result port.
// Depends on lduv_pkg, lduv_parser and lduv_out_buf.
`default_nettype none

// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   lduv_pkg::in_t  (one URL byte or end marker)
// m_        out        m_valid / m_ready   lduv_pkg::out_t (one result per URL)
//
// One request is taken per cycle while s_ready is high; the parser updates its
// state in the cycle a byte arrives, and the result of a URL is registered in
// the cycle after its last request. A result waits in the output register,
// with one skid entry behind it, so requests keep flowing while m_ready is low;
// s_ready drops only when both entries are full. Reset (aresetn low at a clock
// edge) returns the parser to the start of a URL and empties the result buffer.

module ldap_url_validator #(
    parameter int MAX_URL_LEN = 1024
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire lduv_pkg::in_t  s_data,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lduv_pkg::out_t      m_data
);

    logic           accept;
    logic           res_push;
    lduv_pkg::out_t res;

    assign accept = s_valid && s_ready;

    // The parser holds the per-URL state and finishes the result in the
    // cycle of the final request.
    lduv_parser #(
        .MAX_URL_LEN(MAX_URL_LEN)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .item    (s_data),
        .res_push(res_push),
        .res     (res)
    );

    // The buffer decouples result delivery from byte intake.
    lduv_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (res_push),
        .push_data(res),
        .can_push (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // A full skid entry can only exist behind a full output register.
    a_skid_behind_main: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("skid entry full while output register is empty");

    // After a finished URL the output always holds a valid result in the next cycle.
    a_result_appears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.last) |=> m_valid)
        else $error("result of a finished URL did not reach the output");

    // An overlong URL is never reported as valid.
    a_overflow_invalid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overflow) |-> !m_data.url_valid)
        else $error("overflowed URL reported as valid");

    // The prefix length is one of the three scheme cases.
    a_prefix_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.prefix_len == lduv_pkg::PREFIX_NONE ||
                     m_data.prefix_len == lduv_pkg::PREFIX_PLAIN ||
                     m_data.prefix_len == lduv_pkg::PREFIX_SECURE))
        else $error("prefix length out of range");

endmodule

`default_nettype wire

// File: design/lduv_parser.sv
// Per-byte URL parser: phase register, part lengths, prefix tracking.
// Depends on lduv_pkg. Produces the finished result in the cycle of the final item.
`default_nettype none

module lduv_parser #(
    parameter int MAX_URL_LEN = 1024
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          accept,
    input  wire lduv_pkg::in_t item,
    output logic               res_push,
    output lduv_pkg::out_t     res
);

    localparam int POS_W = $clog2(MAX_URL_LEN + 1);
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_URL_LEN);

    typedef enum logic [2:0] {
        PH_START, PH_HOST, PH_PORT, PH_BASEDN, PH_ATTR, PH_DEEP, PH_TRAIL
    } phase_t;

    typedef logic [lduv_pkg::PARTS-1:0][lduv_pkg::LEN_W-1:0] lens_t;

    phase_t                     phase_reg, phase_next;
    logic [POS_W-1:0]           pos_reg, pos_next;
    logic                       vsf_reg, vsf_next;
    logic [lduv_pkg::PARTS-1:0] parts_reg, parts_next;
    lens_t                      lens_reg, lens_next;
    logic                       ovf_reg, ovf_next;
    logic                       in_prefix_reg, in_prefix_next;
    logic                       may_plain_reg, may_plain_next;
    logic                       may_secure_reg, may_secure_next;
    logic [3:0]                 plen_reg, plen_next;

    function automatic logic is_alnum(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
               (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic [lduv_pkg::LEN_W-1:0] grow(input logic [lduv_pkg::LEN_W-1:0] n);
        return (n < lduv_pkg::LEN_SAT) ? n + 1'b1 : n;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic [2:0] idx;
        logic       mp, ms;
        logic       ok;
        c   = item.url_byte;
        idx = pos_reg[2:0];
        mp  = 1'b0;
        ms  = 1'b0;
        ok  = 1'b1;

        phase_next      = phase_reg;
        pos_next        = pos_reg;
        vsf_next        = vsf_reg;
        parts_next      = parts_reg;
        lens_next       = lens_reg;
        ovf_next        = ovf_reg;
        in_prefix_next  = in_prefix_reg;
        may_plain_next  = may_plain_reg;
        may_secure_next = may_secure_reg;
        plen_next       = plen_reg;

        if (accept && !item.end_only) begin
            if (pos_reg >= POS_MAX) begin
                ovf_next = 1'b1;
                vsf_next = 1'b0;
            end else begin
                pos_next = pos_reg + 1'b1;
                // The parser always runs on the raw bytes, so a prefix that turns
                // out not to be a scheme has already been parsed as host or port text.
                if (phase_reg == PH_START && c == lduv_pkg::CH_SLASH) begin
                    parts_next[lduv_pkg::PART_BASEDN] = 1'b1;
                    phase_next = PH_BASEDN;
                end else if (phase_reg == PH_START || phase_reg == PH_HOST ||
                             phase_reg == PH_PORT) begin
                    if (phase_reg == PH_START) begin
                        parts_next[lduv_pkg::PART_HOST] = 1'b1;
                    end
                    if (c == lduv_pkg::CH_SLASH || c == lduv_pkg::CH_QUESTION) begin
                        if (lens_reg[lduv_pkg::PART_HOST] == '0) begin
                            vsf_next = 1'b0;
                        end
                        if (parts_reg[lduv_pkg::PART_PORT] &&
                            lens_reg[lduv_pkg::PART_PORT] == '0) begin
                            vsf_next = 1'b0;
                        end
                        if (c == lduv_pkg::CH_SLASH) begin
                            parts_next[lduv_pkg::PART_BASEDN] = 1'b1;
                            phase_next = PH_BASEDN;
                        end else begin
                            vsf_next   = 1'b0;
                            phase_next = PH_TRAIL;
                        end
                    end else if (phase_reg != PH_PORT && c == lduv_pkg::CH_COLON) begin
                        parts_next[lduv_pkg::PART_PORT] = 1'b1;
                        phase_next = PH_PORT;
                    end else if (phase_reg != PH_PORT) begin
                        phase_next = PH_HOST;
                        lens_next[lduv_pkg::PART_HOST] = grow(lens_reg[lduv_pkg::PART_HOST]);
                        if (!(is_alnum(c) || c == lduv_pkg::CH_DASH ||
                              c == lduv_pkg::CH_DOT)) begin
                            vsf_next = 1'b0;
                        end
                    end else begin
                        lens_next[lduv_pkg::PART_PORT] = grow(lens_reg[lduv_pkg::PART_PORT]);
                        if (!(c >= 8'h30 && c <= 8'h39)) begin
                            vsf_next = 1'b0;
                        end
                    end
                end else if (phase_reg == PH_BASEDN) begin
                    if (c == lduv_pkg::CH_QUESTION) begin
                        if (lens_reg[lduv_pkg::PART_BASEDN] == '0) begin
                            vsf_next = 1'b0;
                        end
                        parts_next[lduv_pkg::PART_ATTR] = 1'b1;
                        phase_next = PH_ATTR;
                    end else begin
                        lens_next[lduv_pkg::PART_BASEDN] =
                            grow(lens_reg[lduv_pkg::PART_BASEDN]);
                        if (c == lduv_pkg::CH_SLASH) begin
                            vsf_next = 1'b0;
                        end
                    end
                end else if (phase_reg == PH_ATTR) begin
                    if (c == lduv_pkg::CH_QUESTION) begin
                        if (lens_reg[lduv_pkg::PART_ATTR] == '0) begin
                            vsf_next = 1'b0;
                        end
                        parts_next[lduv_pkg::PART_DEEP] = 1'b1;
                        phase_next = PH_DEEP;
                    end else begin
                        lens_next[lduv_pkg::PART_ATTR] = grow(lens_reg[lduv_pkg::PART_ATTR]);
                        if (!(is_alnum(c) || c == lduv_pkg::CH_DASH ||
                              c == lduv_pkg::CH_UNDER)) begin
                            vsf_next = 1'b0;
                        end
                    end
                end else if (phase_reg == PH_DEEP) begin
                    if (c == lduv_pkg::CH_QUESTION) begin
                        vsf_next   = 1'b0;
                        phase_next = PH_TRAIL;
                    end else begin
                        lens_next[lduv_pkg::PART_DEEP] = grow(lens_reg[lduv_pkg::PART_DEEP]);
                        if (!(is_alnum(c) || c == lduv_pkg::CH_DASH ||
                              c == lduv_pkg::CH_UNDER)) begin
                            vsf_next = 1'b0;
                        end
                    end
                end

                // Scheme prefix tracking runs next to the parser. A full match
                // throws away what the parser did with the scheme bytes.
                if (in_prefix_reg) begin
                    mp = may_plain_reg && (idx != 3'd7) &&
                         (c == lduv_pkg::scheme_plain(idx));
                    ms = may_secure_reg && (c == lduv_pkg::scheme_secure(idx));
                    may_plain_next  = mp;
                    may_secure_next = ms;
                    if ((mp && idx == 3'd6) || (ms && idx == 3'd7)) begin
                        plen_next      = mp ? lduv_pkg::PREFIX_PLAIN
                                            : lduv_pkg::PREFIX_SECURE;
                        in_prefix_next = 1'b0;
                        phase_next     = PH_START;
                        vsf_next       = 1'b1;
                        parts_next     = '0;
                        lens_next      = '0;
                    end else if (!mp && !ms) begin
                        in_prefix_next = 1'b0;
                    end
                end
            end
        end

        // Closing checks for the part that is open when the URL ends.
        case (phase_next)
            PH_HOST, PH_PORT: begin
                if (lens_next[lduv_pkg::PART_HOST] == '0) begin
                    ok = 1'b0;
                end
                if (parts_next[lduv_pkg::PART_PORT] &&
                    lens_next[lduv_pkg::PART_PORT] == '0) begin
                    ok = 1'b0;
                end
            end
            PH_BASEDN: ok = (lens_next[lduv_pkg::PART_BASEDN] != '0);
            PH_ATTR:   ok = (lens_next[lduv_pkg::PART_ATTR] != '0);
            PH_DEEP:   ok = (lens_next[lduv_pkg::PART_DEEP] != '0);
            default:   ok = 1'b1;
        endcase

        res_push          = accept && item.last;
        res.url_valid     = vsf_next && ok && !ovf_next;
        res.prefix_len    = plen_next;
        res.present_mask  = parts_next;
        res.host_len      = lens_next[lduv_pkg::PART_HOST];
        res.port_len      = lens_next[lduv_pkg::PART_PORT];
        res.basedn_len    = lens_next[lduv_pkg::PART_BASEDN];
        res.attribute_len = lens_next[lduv_pkg::PART_ATTR];
        res.deep_len      = lens_next[lduv_pkg::PART_DEEP];
        res.overflow      = ovf_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || res_push) begin
            phase_reg      <= PH_START;
            pos_reg        <= '0;
            vsf_reg        <= 1'b1;
            parts_reg      <= '0;
            lens_reg       <= '0;
            ovf_reg        <= 1'b0;
            in_prefix_reg  <= 1'b1;
            may_plain_reg  <= 1'b1;
            may_secure_reg <= 1'b1;
            plen_reg       <= lduv_pkg::PREFIX_NONE;
        end else begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            vsf_reg        <= vsf_next;
            parts_reg      <= parts_next;
            lens_reg       <= lens_next;
            ovf_reg        <= ovf_next;
            in_prefix_reg  <= in_prefix_next;
            may_plain_reg  <= may_plain_next;
            may_secure_reg <= may_secure_next;
            plen_reg       <= plen_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lduv_out_buf.sv
// Result register with a skid entry behind it.
// Depends on lduv_pkg for the result struct.
`default_nettype none

module lduv_out_buf (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire lduv_pkg::out_t push_data,
    output logic                can_push,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lduv_pkg::out_t      m_data
);

    logic           main_valid_reg;
    logic           skid_valid_reg;
    lduv_pkg::out_t main_data_reg;
    lduv_pkg::out_t skid_data_reg;
    logic           pop;

    assign pop      = main_valid_reg && m_ready;
    assign can_push = !skid_valid_reg;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (pop && skid_valid_reg) begin
            main_data_reg  <= skid_data_reg;
            skid_valid_reg <= 1'b0;
        end else if (push && (!main_valid_reg || pop)) begin
            main_data_reg  <= push_data;
            main_valid_reg <= 1'b1;
        end else if (push) begin
            skid_data_reg  <= push_data;
            skid_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

endmodule

`default_nettype wire
